>>> rtl/dma_channel_allocator_core_macros.svh
// Assertion macros shared by the channel allocator RTL.
`ifndef DMA_CHANNEL_ALLOCATOR_CORE_MACROS_SVH
`define DMA_CHANNEL_ALLOCATOR_CORE_MACROS_SVH

// Checks that a condition implies a consequence in the same cycle.
`define DCA_ASSERT_SAME(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("channel allocator assertion failed");

// Checks that a condition implies a consequence in the next cycle.
`define DCA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("channel allocator assertion failed");

`endif

>>> rtl/dca_pkg.sv
// Types and codes shared by the channel allocator modules.
package dca_pkg;

   // Item kinds.
   localparam logic [1:0] KIND_REQUEST = 2'd0;
   localparam logic [1:0] KIND_FREE    = 2'd1;
   localparam logic [1:0] KIND_IRQ     = 2'd2;

   // Priority groups.
   localparam logic [1:0] PRIO_HIGH   = 2'd0;
   localparam logic [1:0] PRIO_MEDIUM = 2'd1;
   localparam logic [1:0] PRIO_LOW    = 2'd2;

   // Result codes.
   localparam logic [2:0] RES_GRANTED      = 3'd0;
   localparam logic [2:0] RES_INVALID      = 3'd1;
   localparam logic [2:0] RES_NONE_FREE    = 3'd2;
   localparam logic [2:0] RES_FREED        = 3'd3;
   localparam logic [2:0] RES_ALREADY_FREE = 3'd4;
   localparam logic [2:0] RES_DISPATCH     = 3'd5;
   localparam logic [2:0] RES_SPURIOUS     = 3'd6;
   localparam logic [2:0] RES_NOTHING      = 3'd7;

   typedef struct packed {
      logic [1:0]  kind;
      logic [1:0]  priority_req;
      logic        requester_valid;
      logic [7:0]  owner_tag;
      logic [3:0]  channel_in;
      logic [15:0] pending_mask;
   } req_type;

   typedef struct packed {
      logic [2:0] result_code;
      logic [3:0] channel_out;
      logic [7:0] tag_out;
      logic       clear_status;
      logic       last;
   } rsp_type;

   typedef enum logic {
      ST_IDLE,
      ST_WALK
   } state_type;

   typedef enum logic [2:0] {
      CMD_NONE,
      CMD_REQUEST,
      CMD_FREE,
      CMD_LOAD_IRQ,
      CMD_STEP
   } cmd_type;

   // Controller to datapath.
   typedef struct packed {
      cmd_type cmd;
   } ctl_type;

   // Datapath to controller.
   typedef struct packed {
      logic irq_empty;
      logic walk_last;
   } sts_type;

endpackage

>>> rtl/dca_control.sv
// Controller state machine that sequences items through the datapath.
module dca_control (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [1:0]        kind,
   input  dca_pkg::sts_type  sts,
   output dca_pkg::ctl_type  ctl,
   output logic              busy
);

   dca_pkg::state_type state_ff;
   dca_pkg::state_type state_in;

   // State register.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= dca_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and datapath commands.
   always_comb begin
      state_in = state_ff;
      ctl.cmd  = dca_pkg::CMD_NONE;
      case (state_ff)
         dca_pkg::ST_IDLE: begin
            if (start) begin
               case (kind)
                  dca_pkg::KIND_REQUEST: ctl.cmd = dca_pkg::CMD_REQUEST;
                  dca_pkg::KIND_FREE:    ctl.cmd = dca_pkg::CMD_FREE;
                  dca_pkg::KIND_IRQ: begin
                     ctl.cmd = dca_pkg::CMD_LOAD_IRQ;
                     if (!sts.irq_empty) begin
                        state_in = dca_pkg::ST_WALK;
                     end
                  end
                  default: ctl.cmd = dca_pkg::CMD_NONE;
               endcase
            end
         end
         dca_pkg::ST_WALK: begin
            ctl.cmd = dca_pkg::CMD_STEP;
            if (sts.walk_last) begin
               state_in = dca_pkg::ST_IDLE;
            end
         end
         default: state_in = dca_pkg::ST_IDLE;
      endcase
   end

   assign busy = (state_ff == dca_pkg::ST_WALK);

endmodule

>>> rtl/dca_datapath.sv
// Datapath: ownership map, tag store, channel search, mask walk, result register.
module dca_datapath #(
   parameter int NUM_CHANNELS = 16,
   parameter int GROUP_SIZE   = 4,
   parameter int TAG_WIDTH    = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  dca_pkg::ctl_type  ctl,
   input  dca_pkg::req_type  req_item,
   output dca_pkg::sts_type  sts,
   output dca_pkg::rsp_type  rsp_item,
   output logic              rsp_strobe
);

   localparam int CH_W    = $clog2(NUM_CHANNELS);
   localparam int CNT_W   = $clog2(NUM_CHANNELS + 1);
   localparam int MW      = (NUM_CHANNELS < 16) ? NUM_CHANNELS : 16;
   localparam int WP_W    = $clog2(MW);
   localparam int LO_MED  = (GROUP_SIZE < NUM_CHANNELS) ? GROUP_SIZE : NUM_CHANNELS;
   localparam int LO_LOW  = (2 * GROUP_SIZE < NUM_CHANNELS) ? 2 * GROUP_SIZE : NUM_CHANNELS;

   logic [NUM_CHANNELS-1:0] owned_ff;
   logic [NUM_CHANNELS-1:0] owned_in;
   logic [TAG_WIDTH-1:0]    tags_ff [NUM_CHANNELS];
   logic [TAG_WIDTH-1:0]    tag_rd_ff;
   logic [MW-1:0]           rem_ff;
   logic [MW-1:0]           rem_in;
   dca_pkg::rsp_type        rsp_ff;
   dca_pkg::rsp_type        rsp_in;
   logic                    valid_ff;
   logic                    valid_in;

   logic                    tag_we;
   logic [CH_W-1:0]         tag_wa;

   logic [CNT_W-1:0]        lo_bound;
   logic [CNT_W-1:0]        hi_bound;
   logic                    grp_found;
   logic [CH_W-1:0]         grp_idx;
   logic                    below_found;
   logic [CH_W-1:0]         below_idx;
   logic [CH_W-1:0]         grant_idx;
   logic                    req_bad;

   logic                    free_in_range;
   logic [CH_W-1:0]         free_idx;

   logic [MW-1:0]           irq_mask;
   logic [WP_W-1:0]         walk_pos;
   logic [CH_W-1:0]         walk_ch;

   // Group bounds for the requested priority.
   always_comb begin
      case (req_item.priority_req)
         dca_pkg::PRIO_HIGH: begin
            lo_bound = '0;
            hi_bound = CNT_W'(LO_MED);
         end
         dca_pkg::PRIO_MEDIUM: begin
            lo_bound = CNT_W'(LO_MED);
            hi_bound = CNT_W'(LO_LOW);
         end
         default: begin
            lo_bound = CNT_W'(LO_LOW);
            hi_bound = CNT_W'(NUM_CHANNELS);
         end
      endcase
      req_bad = !req_item.requester_valid ||
                !(req_item.priority_req inside
                  {dca_pkg::PRIO_HIGH, dca_pkg::PRIO_MEDIUM, dca_pkg::PRIO_LOW});
   end

   // Lowest free channel inside the group, highest free channel below it.
   always_comb begin
      grp_found   = 1'b0;
      grp_idx     = '0;
      below_found = 1'b0;
      below_idx   = '0;
      for (int i = NUM_CHANNELS - 1; i >= 0; i--) begin
         if (CNT_W'(i) >= lo_bound && CNT_W'(i) < hi_bound && !owned_ff[i]) begin
            grp_found = 1'b1;
            grp_idx   = CH_W'(i);
         end
      end
      for (int i = 0; i < NUM_CHANNELS; i++) begin
         if (CNT_W'(i) < lo_bound && !owned_ff[i]) begin
            below_found = 1'b1;
            below_idx   = CH_W'(i);
         end
      end
      grant_idx = grp_found ? grp_idx : below_idx;
   end

   // Free target and interrupt walk position.
   always_comb begin
      free_in_range = ({2'b00, req_item.channel_in} < 6'(NUM_CHANNELS));
      free_idx      = CH_W'(req_item.channel_in);
      irq_mask      = req_item.pending_mask[MW-1:0];
      walk_pos      = '0;
      for (int i = MW - 1; i >= 0; i--) begin
         if (rem_ff[i]) begin
            walk_pos = WP_W'(i);
         end
      end
      walk_ch = CH_W'(walk_pos);
   end

   assign sts.irq_empty = (irq_mask == '0);
   assign sts.walk_last = ((rem_ff & (rem_ff - 1'b1)) == '0);

   // Command execution and result formation.
   always_comb begin
      owned_in = owned_ff;
      rem_in   = rem_ff;
      rsp_in   = '0;
      valid_in = 1'b0;
      tag_we   = 1'b0;
      tag_wa   = grant_idx;
      case (ctl.cmd)
         dca_pkg::CMD_REQUEST: begin
            valid_in    = 1'b1;
            rsp_in.last = 1'b1;
            if (req_bad) begin
               rsp_in.result_code = dca_pkg::RES_INVALID;
            end else if (grp_found || below_found) begin
               owned_in[grant_idx] = 1'b1;
               tag_we              = 1'b1;
               rsp_in.result_code  = dca_pkg::RES_GRANTED;
               rsp_in.channel_out  = 4'(grant_idx);
               rsp_in.clear_status = 1'b1;
            end else begin
               rsp_in.result_code = dca_pkg::RES_NONE_FREE;
            end
         end
         dca_pkg::CMD_FREE: begin
            valid_in           = 1'b1;
            rsp_in.last        = 1'b1;
            rsp_in.channel_out = req_item.channel_in;
            if (free_in_range && owned_ff[free_idx]) begin
               owned_in[free_idx]  = 1'b0;
               rsp_in.result_code  = dca_pkg::RES_FREED;
               rsp_in.clear_status = 1'b1;
            end else begin
               rsp_in.result_code = dca_pkg::RES_ALREADY_FREE;
            end
         end
         dca_pkg::CMD_LOAD_IRQ: begin
            rem_in = irq_mask;
            if (irq_mask == '0) begin
               valid_in           = 1'b1;
               rsp_in.last        = 1'b1;
               rsp_in.result_code = dca_pkg::RES_NOTHING;
            end
         end
         dca_pkg::CMD_STEP: begin
            valid_in           = 1'b1;
            rsp_in.channel_out = 4'(walk_ch);
            rsp_in.last        = sts.walk_last;
            rem_in             = rem_ff & (rem_ff - 1'b1);
            if (owned_ff[walk_ch]) begin
               rsp_in.result_code = dca_pkg::RES_DISPATCH;
            end else begin
               rsp_in.result_code  = dca_pkg::RES_SPURIOUS;
               rsp_in.clear_status = 1'b1;
            end
         end
         default: valid_in = 1'b0;
      endcase
   end

   // Control state: ownership map and result strobe.
   always_ff @(posedge clock) begin
      if (reset) begin
         owned_ff <= '0;
         valid_ff <= 1'b0;
      end else begin
         owned_ff <= owned_in;
         valid_ff <= valid_in;
      end
   end

   // Payload state: walk mask, result register, tag store and its read port.
   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      rsp_ff <= rsp_in;
      if (ctl.cmd == dca_pkg::CMD_STEP) begin
         tag_rd_ff <= tags_ff[walk_ch];
      end
      if (tag_we) begin
         tags_ff[tag_wa] <= TAG_WIDTH'(req_item.owner_tag);
      end
   end

   // Result port; a dispatch carries the tag read from the store in the same step.
   always_comb begin
      rsp_item = rsp_ff;
      if (rsp_ff.result_code == dca_pkg::RES_DISPATCH) begin
         rsp_item.tag_out = 8'(tag_rd_ff);
      end
   end

   assign rsp_strobe = valid_ff;

endmodule

>>> rtl/dma_channel_allocator_core.sv
// Top level of the DMA channel allocator: controller, datapath and checks.
//
// Usage: an item is presented on req_item with start high and is taken at a
// clock edge where busy is low. A request grants a channel from its priority
// group (or the highest free channel below it), a free releases a channel,
// and an interrupt walks its pending mask. Items of an unknown kind are taken
// and give no result.
// Results appear on rsp_item for exactly one cycle, marked by rsp_strobe,
// from the register loaded at the edge that produced them. rsp_item.last marks the final
// result of an item.
// Requests and frees leave busy low, so a new item may follow in the next
// cycle. An interrupt with pending channels raises busy and emits one result
// per cycle for each set bit of the mask, as the mask walk of the datapath
// steps through it.
// The receiver cannot stall: every result must be taken when strobed.
// Reset marks every channel free; owner tags are only put out for owned channels.
module dma_channel_allocator_core #(
   parameter int NUM_CHANNELS = 16,
   parameter int GROUP_SIZE   = 4,
   parameter int TAG_WIDTH    = 8
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  dca_pkg::req_type  req_item,
   output dca_pkg::rsp_type  rsp_item,
   output logic              rsp_strobe
);

   `include "dma_channel_allocator_core_macros.svh"

   dca_pkg::ctl_type ctl;
   dca_pkg::sts_type sts;

   // Sequencing of items.
   dca_control u_control (
      .clock (clock),
      .reset (reset),
      .start (start),
      .kind  (req_item.kind),
      .sts   (sts),
      .ctl   (ctl),
      .busy  (busy)
   );

   // Channel state and result formation.
   dca_datapath #(
      .NUM_CHANNELS (NUM_CHANNELS),
      .GROUP_SIZE   (GROUP_SIZE),
      .TAG_WIDTH    (TAG_WIDTH)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctl        (ctl),
      .req_item   (req_item),
      .sts        (sts),
      .rsp_item   (rsp_item),
      .rsp_strobe (rsp_strobe)
   );

   // The final walk step ends the interrupt with a last result.
   `DCA_ASSERT_NEXT(a_walk_ends, clock, reset, (ctl.cmd == dca_pkg::CMD_STEP) && sts.walk_last, !busy && rsp_strobe && rsp_item.last)

   // Every walk step yields a dispatch or a spurious notice.
   `DCA_ASSERT_NEXT(a_step_result, clock, reset, ctl.cmd == dca_pkg::CMD_STEP, rsp_strobe && ((rsp_item.result_code == dca_pkg::RES_DISPATCH) || (rsp_item.result_code == dca_pkg::RES_SPURIOUS)))

   // An accepted request gives exactly one final result.
   `DCA_ASSERT_NEXT(a_request_done, clock, reset, start && !busy && (req_item.kind == dca_pkg::KIND_REQUEST), rsp_strobe && rsp_item.last)

   // No final result is shown while a walk is still running.
   `DCA_ASSERT_SAME(a_no_last_busy, clock, reset, busy, !(rsp_strobe && rsp_item.last))

endmodule

>>> sim/tb_dma_channel_allocator_core.sv
// Self-checking testbench for the DMA channel allocator core.
module tb_dma_channel_allocator_core;
   import dca_pkg::*;

   localparam int NUM_CH       = 16;
   localparam int GROUP        = 4;
   localparam int RANDOM_ITEMS = 500;
   localparam int CYCLE_LIMIT  = 200000;
   localparam int DRAIN_CYCLES = 24;

   // Codes the package leaves unnamed.
   localparam logic [1:0] KIND_UNUSED  = 2'd3;
   localparam logic [1:0] PRIO_UNKNOWN = 2'd3;

   // Traffic mix of one burst.
   typedef enum int {
      MODE_FILL,
      MODE_DRAIN,
      MODE_MIXED
   } mix_type;

   // Channel ownership tracker and queue of results the block still owes.
   class alloc_scoreboard;
      logic [NUM_CH-1:0] owner_map;
      logic [7:0]        tag_store [NUM_CH];
      rsp_type           due_results [$];
      int                errors;
      int                results_seen;
      int                code_hits [8];

      function new();
         owner_map = '0;
         errors = 0;
         results_seen = 0;
         foreach (code_hits[i]) code_hits[i] = 0;
      endfunction

      function void push(logic [2:0] code, int ch, logic [7:0] tag, logic clr, logic lst);
         rsp_type r;
         r.result_code  = code;
         r.channel_out  = 4'(ch);
         r.tag_out      = tag;
         r.clear_status = clr;
         r.last         = lst;
         due_results.push_back(r);
      endfunction

      // Works out the results of one accepted item and updates the map.
      function void note_item(req_type it);
         int lo;
         int hi;
         int found;
         int top;
         int i;
         found = -1;
         top = -1;
         case (it.kind)
            KIND_REQUEST: begin
               if (!it.requester_valid || it.priority_req > PRIO_LOW) begin
                  push(RES_INVALID, 0, 8'h00, 1'b0, 1'b1);
               end else begin
                  lo = int'(it.priority_req) * GROUP;
                  hi = (it.priority_req == PRIO_LOW) ? NUM_CH : lo + GROUP;
                  // Lowest free channel of the own group first.
                  for (i = lo; i < hi && found < 0; i++) begin
                     if (!owner_map[i]) found = i;
                  end
                  // Otherwise the highest free channel below the group.
                  for (i = lo - 1; i >= 0 && found < 0; i--) begin
                     if (!owner_map[i]) found = i;
                  end
                  if (found < 0) begin
                     push(RES_NONE_FREE, 0, 8'h00, 1'b0, 1'b1);
                  end else begin
                     owner_map[found] = 1'b1;
                     tag_store[found] = it.owner_tag;
                     push(RES_GRANTED, found, 8'h00, 1'b1, 1'b1);
                  end
               end
            end
            KIND_FREE: begin
               if (!owner_map[it.channel_in]) begin
                  push(RES_ALREADY_FREE, it.channel_in, 8'h00, 1'b0, 1'b1);
               end else begin
                  owner_map[it.channel_in] = 1'b0;
                  push(RES_FREED, it.channel_in, 8'h00, 1'b1, 1'b1);
               end
            end
            KIND_IRQ: begin
               // The highest pending bit carries the last flag.
               for (i = 0; i < NUM_CH; i++) begin
                  if (it.pending_mask[i]) top = i;
               end
               if (top < 0) push(RES_NOTHING, 0, 8'h00, 1'b0, 1'b1);
               for (i = 0; i <= top; i++) begin
                  if (it.pending_mask[i]) begin
                     if (owner_map[i]) push(RES_DISPATCH, i, tag_store[i], 1'b0, i == top);
                     else push(RES_SPURIOUS, i, 8'h00, 1'b1, i == top);
                  end
               end
            end
            default: ;
         endcase
      endfunction

      function void compare_field(string name, logic [7:0] want_v, logic [7:0] got_v);
         if (got_v !== want_v) begin
            errors++;
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want_v, got_v);
         end
      endfunction

      // Compares one strobed result with the oldest outstanding one.
      function void check_result(rsp_type got);
         rsp_type want;
         results_seen++;
         if (due_results.size() == 0) begin
            errors++;
            $display("%0t: result with nothing outstanding: expected none, actual code %0h ch %0h",
                     $time, got.result_code, got.channel_out);
         end else begin
            want = due_results.pop_front();
            code_hits[want.result_code]++;
            compare_field("result_code", 8'(want.result_code), 8'(got.result_code));
            compare_field("channel_out", 8'(want.channel_out), 8'(got.channel_out));
            compare_field("tag_out", want.tag_out, got.tag_out);
            compare_field("clear_status", 8'(want.clear_status), 8'(got.clear_status));
            compare_field("last", 8'(want.last), 8'(got.last));
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   rsp_type rsp_item;
   logic    rsp_strobe;

   alloc_scoreboard sb;
   int cycle_count = 0;
   int items_sent = 0;

   dma_channel_allocator_core u_top (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .busy       (busy),
      .req_item   (req_item),
      .rsp_item   (rsp_item),
      .rsp_strobe (rsp_strobe)
   );

   // Clock with a period of 10.
   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Every strobed result is checked at the edge that ends its cycle.
   always @(posedge clock) begin
      if (!reset && rsp_strobe === 1'b1) sb.check_result(rsp_item);
   end

   // Run limit.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles with %0d results outstanding.",
                  cycle_count, sb.due_results.size());
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   function automatic req_type make_item(logic [1:0] kind, logic [1:0] prio, logic valid,
                                         logic [7:0] tag, logic [3:0] ch, logic [15:0] mask);
      req_type it;
      it.kind            = kind;
      it.priority_req    = prio;
      it.requester_valid = valid;
      it.owner_tag       = tag;
      it.channel_in      = ch;
      it.pending_mask    = mask;
      return it;
   endfunction

   // Random item; frees and interrupt masks lean on the current ownership map.
   function automatic req_type random_item(mix_type mix);
      req_type it;
      int roll;
      int req_w;
      int free_w;
      int pick;
      it.priority_req    = 2'($urandom_range(0, 3));
      it.requester_valid = 1'($urandom_range(0, 1));
      it.owner_tag       = 8'($urandom_range(0, 255));
      it.channel_in      = 4'($urandom_range(0, 15));
      it.pending_mask    = 16'($urandom_range(0, 65535));
      case (mix)
         MODE_FILL: begin
            req_w = 60;
            free_w = 15;
         end
         MODE_DRAIN: begin
            req_w = 15;
            free_w = 60;
         end
         default: begin
            req_w = 35;
            free_w = 35;
         end
      endcase
      roll = $urandom_range(0, 99);
      if (roll < req_w) begin
         it.kind = KIND_REQUEST;
         it.requester_valid = ($urandom_range(0, 9) != 0);
         it.priority_req = ($urandom_range(0, 19) == 0) ? PRIO_UNKNOWN
                                                         : 2'($urandom_range(0, 2));
      end else if (roll < req_w + free_w) begin
         it.kind = KIND_FREE;
         // Mostly free a channel that is actually owned.
         if (sb.owner_map != '0 && $urandom_range(0, 3) != 0) begin
            pick = $urandom_range(0, NUM_CH - 1);
            while (!sb.owner_map[pick]) pick = (pick + 1) % NUM_CH;
            it.channel_in = 4'(pick);
         end
      end else if (roll < 97) begin
         it.kind = KIND_IRQ;
         case ($urandom_range(0, 3))
            0: it.pending_mask = 16'(1 << $urandom_range(0, 15));
            1: it.pending_mask = sb.owner_map;
            2: it.pending_mask = sb.owner_map | 16'(1 << $urandom_range(0, 15));
            default: ;
         endcase
      end else begin
         it.kind = KIND_UNUSED;
      end
      return it;
   endfunction

   // Presents one item and holds it until the block takes it.
   task automatic send_item(input req_type it);
      start <= 1'b1;
      req_item <= it;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      sb.note_item(it);
      items_sent++;
   endtask

   // Sender gap with noise on the item bus.
   task automatic idle_gap(input int cycles);
      if (cycles > 0) begin
         start <= 1'b0;
         req_item <= random_item(MODE_MIXED);
         repeat (cycles) @(posedge clock);
      end
   endtask

   // Holds off until every outstanding result has come.
   task automatic wait_drained();
      start <= 1'b0;
      while (sb.due_results.size() != 0) @(posedge clock);
   endtask

   initial begin
      req_type it;
      mix_type mix;
      int random_count;
      int burst;
      int k;
      bit paused;
      sb = new();
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      random_count = 0;
      paused = 1'b0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // Invalid requests, empty and all-spurious interrupts, free of a free channel.
      send_item(make_item(KIND_REQUEST, PRIO_HIGH, 1'b0, 8'hff, 4'd0, 16'h0000));
      send_item(make_item(KIND_REQUEST, PRIO_UNKNOWN, 1'b1, 8'h00, 4'd15, 16'hffff));
      send_item(make_item(KIND_IRQ, PRIO_HIGH, 1'b0, 8'h00, 4'd0, 16'h0000));
      send_item(make_item(KIND_IRQ, PRIO_LOW, 1'b1, 8'hff, 4'd15, 16'hffff));
      send_item(make_item(KIND_FREE, PRIO_HIGH, 1'b0, 8'h00, 4'd0, 16'h0000));
      // Fill the high group, then one more high request finds nothing.
      send_item(make_item(KIND_REQUEST, PRIO_HIGH, 1'b1, 8'h00, 4'd0, 16'h0000));
      send_item(make_item(KIND_REQUEST, PRIO_HIGH, 1'b1, 8'hff, 4'd0, 16'h0000));
      send_item(make_item(KIND_REQUEST, PRIO_HIGH, 1'b1, 8'h5a, 4'd0, 16'h0000));
      send_item(make_item(KIND_REQUEST, PRIO_HIGH, 1'b1, 8'ha5, 4'd0, 16'h0000));
      send_item(make_item(KIND_REQUEST, PRIO_HIGH, 1'b1, 8'h3c, 4'd0, 16'h0000));
      // Fill the medium group, free a high channel, and fall back into it.
      send_item(make_item(KIND_REQUEST, PRIO_MEDIUM, 1'b1, 8'h11, 4'd0, 16'h0000));
      send_item(make_item(KIND_REQUEST, PRIO_MEDIUM, 1'b1, 8'h22, 4'd0, 16'h0000));
      send_item(make_item(KIND_REQUEST, PRIO_MEDIUM, 1'b1, 8'h33, 4'd0, 16'h0000));
      send_item(make_item(KIND_REQUEST, PRIO_MEDIUM, 1'b1, 8'h44, 4'd0, 16'h0000));
      send_item(make_item(KIND_FREE, PRIO_HIGH, 1'b0, 8'h00, 4'd2, 16'h0000));
      send_item(make_item(KIND_REQUEST, PRIO_MEDIUM, 1'b1, 8'h77, 4'd0, 16'h0000));
      send_item(make_item(KIND_REQUEST, PRIO_LOW, 1'b1, 8'h88, 4'd0, 16'h0000));
      // Mixed dispatch and spurious walk, ignored kind, edge channels.
      send_item(make_item(KIND_IRQ, PRIO_HIGH, 1'b0, 8'h00, 4'd0, 16'hffff));
      send_item(make_item(KIND_UNUSED, PRIO_LOW, 1'b1, 8'hff, 4'd15, 16'hffff));
      send_item(make_item(KIND_FREE, PRIO_HIGH, 1'b0, 8'h00, 4'd15, 16'h0000));
      send_item(make_item(KIND_FREE, PRIO_HIGH, 1'b0, 8'h00, 4'd3, 16'h0000));
      send_item(make_item(KIND_IRQ, PRIO_HIGH, 1'b0, 8'h00, 4'd0, 16'h8001));
      wait_drained();

      // Random bursts; one pause halfway lets the block run dry.
      while (random_count < RANDOM_ITEMS) begin
         mix = mix_type'($urandom_range(0, 2));
         burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 10);
         for (k = 0; k < burst; k++) begin
            it = random_item(mix);
            send_item(it);
            if (it.kind != KIND_UNUSED) random_count++;
         end
         if (!paused && random_count >= RANDOM_ITEMS / 2) begin
            wait_drained();
            paused = 1'b1;
         end else begin
            idle_gap(($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8));
         end
      end

      // Let the last results arrive and watch for strays.
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Summary: %0d items taken, %0d results checked, %0d mismatches.",
               items_sent, sb.results_seen, sb.errors);
      $display("Outcomes: %0d grants, %0d none free, %0d freed, %0d already free, %0d dispatches, %0d spurious.",
               sb.code_hits[RES_GRANTED], sb.code_hits[RES_NONE_FREE], sb.code_hits[RES_FREED],
               sb.code_hits[RES_ALREADY_FREE], sb.code_hits[RES_DISPATCH],
               sb.code_hits[RES_SPURIOUS]);
      if (sb.errors == 0 && sb.due_results.size() == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
